// File: rtl/cpu_6502_execute_unit_defines.svh
// Assertion macros shared by the execute unit's checker.
`ifndef CPU_6502_EXECUTE_UNIT_DEFINES_SVH
`define CPU_6502_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define C65EX_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define C65EX_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/c65ex_pkg.sv
// Shared types and constants of the 6502 execute unit.
`default_nettype none

package c65ex_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] SP_RESET  = 8'hFD;
  localparam logic [7:0] SIGN_MASK = 8'h80;
  localparam logic [7:0] ALL_ONES  = 8'hFF;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,
    OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,
    OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BVC = 6'd10, OP_BVS = 6'd11,
    OP_CLC = 6'd12, OP_CLD = 6'd13, OP_CLI = 6'd14, OP_CLV = 6'd15,
    OP_CMP = 6'd16, OP_CPX = 6'd17, OP_CPY = 6'd18, OP_DEC = 6'd19,
    OP_DEX = 6'd20, OP_DEY = 6'd21, OP_EOR = 6'd22, OP_INC = 6'd23,
    OP_INX = 6'd24, OP_INY = 6'd25, OP_LDA = 6'd26, OP_LDX = 6'd27,
    OP_LDY = 6'd28, OP_LSR = 6'd29, OP_NOP = 6'd30, OP_ORA = 6'd31,
    OP_PHA = 6'd32, OP_PHP = 6'd33, OP_PLA = 6'd34, OP_PLP = 6'd35,
    OP_ROL = 6'd36, OP_ROR = 6'd37, OP_SBC = 6'd38, OP_SEC = 6'd39,
    OP_SED = 6'd40, OP_SEI = 6'd41, OP_STA = 6'd42, OP_STX = 6'd43,
    OP_STY = 6'd44, OP_TAX = 6'd45, OP_TAY = 6'd46, OP_TSX = 6'd47,
    OP_TXA = 6'd48, OP_TXS = 6'd49, OP_TYA = 6'd50
  } op_t;

  // Which flag a conditional branch tests.
  typedef enum logic [1:0] {
    BR_C = 2'd0,
    BR_Z = 2'd1,
    BR_N = 2'd2,
    BR_V = 2'd3
  } br_flag_t;

  // Classified instruction as held in the queue.
  typedef struct packed {
    op_t        op;
    logic [7:0] operand;
    logic       shift_acc;
    logic       mem_write;
    logic       push;
    logic       is_branch;
    br_flag_t   br_flag;
    logic       br_when_set;
  } dec_t;

  // One finished result; result_byte sits lowest.
  typedef struct packed {
    logic       branch_taken;
    logic       push_stack;
    logic       write_memory;
    logic [7:0] status_out;
    logic [7:0] stack_pointer_out;
    logic [7:0] index_y_out;
    logic [7:0] index_x_out;
    logic [7:0] accumulator_out;
    logic [7:0] result_byte;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/c65ex_decode.sv
// Front end: classifies an incoming instruction item.
`default_nettype none

module c65ex_decode (
  input  wire logic [5:0]   operation,
  input  wire logic [7:0]   operand,
  input  wire logic         on_accumulator,
  output c65ex_pkg::dec_t   dec
);
  import c65ex_pkg::*;

  op_t op;

  // Unused kinds collapse to NOP.
  assign op = (operation > 6'(OP_TYA)) ? OP_NOP : op_t'(operation);

  always_comb begin
    dec             = '0;
    dec.op          = op;
    dec.operand     = operand;
    dec.br_flag     = BR_C;
    case (op)
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        dec.shift_acc = on_accumulator;
        dec.mem_write = !on_accumulator;
      end
      OP_DEC, OP_INC, OP_STA, OP_STX, OP_STY: begin
        dec.mem_write = 1'b1;
      end
      OP_PHA, OP_PHP: begin
        dec.push = 1'b1;
      end
      OP_BCC: begin
        dec.is_branch = 1'b1; dec.br_flag = BR_C; dec.br_when_set = 1'b0;
      end
      OP_BCS: begin
        dec.is_branch = 1'b1; dec.br_flag = BR_C; dec.br_when_set = 1'b1;
      end
      OP_BEQ: begin
        dec.is_branch = 1'b1; dec.br_flag = BR_Z; dec.br_when_set = 1'b1;
      end
      OP_BNE: begin
        dec.is_branch = 1'b1; dec.br_flag = BR_Z; dec.br_when_set = 1'b0;
      end
      OP_BMI: begin
        dec.is_branch = 1'b1; dec.br_flag = BR_N; dec.br_when_set = 1'b1;
      end
      OP_BPL: begin
        dec.is_branch = 1'b1; dec.br_flag = BR_N; dec.br_when_set = 1'b0;
      end
      OP_BVS: begin
        dec.is_branch = 1'b1; dec.br_flag = BR_V; dec.br_when_set = 1'b1;
      end
      OP_BVC: begin
        dec.is_branch = 1'b1; dec.br_flag = BR_V; dec.br_when_set = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/c65ex_queue.sv
// Small FIFO between the front and back ends.
`default_nettype none

module c65ex_queue #(
  parameter int unsigned DEPTH = c65ex_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wr_en,
  input  c65ex_pkg::dec_t      wr_item,
  output logic                 full,
  input  wire logic            rd_en,
  output c65ex_pkg::dec_t      rd_item,
  output logic                 not_empty
);
  import c65ex_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  dec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/c65ex_execute.sv
// Back end: register file, flags, ALU pass and the output register.
`default_nettype none

module c65ex_execute (
  input  wire logic        clk,
  input  wire logic        rst,
  input  c65ex_pkg::dec_t  q_item,
  input  wire logic        q_valid,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output c65ex_pkg::res_t  out_item
);
  import c65ex_pkg::*;

  logic [7:0] acc, idx_x, idx_y, sp;
  logic       fn, fv, fb, fd, fi, fz, fc;

  logic [7:0] acc_next, idx_x_next, idx_y_next, sp_next;
  logic       fn_next, fv_next, fd_next, fi_next, fz_next, fc_next;

  logic [7:0] m;
  logic [7:0] add_b;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [8:0] diff;
  logic [7:0] sh_src;
  logic [7:0] sh_val;
  logic [7:0] nz_val;
  logic       upd_nz;
  logic [7:0] res;
  logic       br_sel;
  logic       taken;

  assign m       = q_item.operand;
  assign add_b   = (q_item.op == OP_SBC) ? ~m : m;
  assign sum     = {1'b0, acc} + {1'b0, add_b} + {8'd0, fc};
  assign cmp_reg = (q_item.op == OP_CPX) ? idx_x :
                   (q_item.op == OP_CPY) ? idx_y : acc;
  assign diff    = {1'b0, cmp_reg} - {1'b0, m};
  assign sh_src  = q_item.shift_acc ? acc : m;

  always_comb begin
    case (q_item.br_flag)
      BR_C:    br_sel = fc;
      BR_Z:    br_sel = fz;
      BR_N:    br_sel = fn;
      BR_V:    br_sel = fv;
      default: br_sel = fc;
    endcase
    taken = q_item.is_branch && (br_sel == q_item.br_when_set);
  end

  always_comb begin
    acc_next   = acc;
    idx_x_next = idx_x;
    idx_y_next = idx_y;
    sp_next    = sp;
    fn_next    = fn;
    fv_next    = fv;
    fd_next    = fd;
    fi_next    = fi;
    fz_next    = fz;
    fc_next    = fc;
    nz_val     = '0;
    upd_nz     = 1'b0;
    res        = '0;
    sh_val     = sh_src;
    case (q_item.op)
      OP_ADC, OP_SBC: begin
        acc_next = sum[7:0];
        fc_next  = sum[8];
        fv_next  = ((~(acc ^ add_b)) & (acc ^ sum[7:0]) & SIGN_MASK) != '0;
        nz_val = sum[7:0]; upd_nz = 1'b1;
      end
      OP_AND: begin acc_next = acc & m; nz_val = acc & m; upd_nz = 1'b1; end
      OP_EOR: begin acc_next = acc ^ m; nz_val = acc ^ m; upd_nz = 1'b1; end
      OP_ORA: begin acc_next = acc | m; nz_val = acc | m; upd_nz = 1'b1; end
      OP_ASL: begin
        fc_next = sh_src[7];
        sh_val  = {sh_src[6:0], 1'b0};
      end
      OP_LSR: begin
        fc_next = sh_src[0];
        sh_val  = {1'b0, sh_src[7:1]};
      end
      OP_ROL: begin
        fc_next = sh_src[7];
        sh_val  = {sh_src[6:0], fc};
      end
      OP_ROR: begin
        fc_next = sh_src[0];
        sh_val  = {fc, sh_src[7:1]};
      end
      OP_BIT: begin
        fn_next = m[7];
        fv_next = m[6];
        fz_next = ((acc & m) == '0);
      end
      OP_CLC: fc_next = 1'b0;
      OP_CLD: fd_next = 1'b0;
      OP_CLI: fi_next = 1'b0;
      OP_CLV: fv_next = 1'b0;
      OP_SEC: fc_next = 1'b1;
      OP_SED: fd_next = 1'b1;
      OP_SEI: fi_next = 1'b1;
      OP_CMP, OP_CPX, OP_CPY: begin
        fc_next = !diff[8];
        nz_val = diff[7:0]; upd_nz = 1'b1;
      end
      OP_DEC: begin res = m + ALL_ONES; nz_val = m + ALL_ONES; upd_nz = 1'b1; end
      OP_INC: begin res = m + 8'd1; nz_val = m + 8'd1; upd_nz = 1'b1; end
      OP_DEX: begin
        idx_x_next = idx_x + ALL_ONES; nz_val = idx_x + ALL_ONES; upd_nz = 1'b1;
      end
      OP_DEY: begin
        idx_y_next = idx_y + ALL_ONES; nz_val = idx_y + ALL_ONES; upd_nz = 1'b1;
      end
      OP_INX: begin
        idx_x_next = idx_x + 8'd1; nz_val = idx_x + 8'd1; upd_nz = 1'b1;
      end
      OP_INY: begin
        idx_y_next = idx_y + 8'd1; nz_val = idx_y + 8'd1; upd_nz = 1'b1;
      end
      OP_LDA: begin acc_next = m; nz_val = m; upd_nz = 1'b1; end
      OP_LDX: begin idx_x_next = m; nz_val = m; upd_nz = 1'b1; end
      OP_LDY: begin idx_y_next = m; nz_val = m; upd_nz = 1'b1; end
      OP_PHA: begin res = acc; sp_next = sp + ALL_ONES; end
      OP_PHP: begin
        res     = {fn, fv, 1'b1, 1'b1, fd, fi, fz, fc};
        sp_next = sp + ALL_ONES;
      end
      OP_PLA: begin
        sp_next = sp + 8'd1;
        acc_next = m; nz_val = m; upd_nz = 1'b1;
      end
      OP_PLP: begin
        sp_next = sp + 8'd1;
        fn_next = m[7]; fv_next = m[6]; fd_next = m[3];
        fi_next = m[2]; fz_next = m[1]; fc_next = m[0];
      end
      OP_STA: res = acc;
      OP_STX: res = idx_x;
      OP_STY: res = idx_y;
      OP_TAX: begin idx_x_next = acc; nz_val = acc; upd_nz = 1'b1; end
      OP_TAY: begin idx_y_next = acc; nz_val = acc; upd_nz = 1'b1; end
      OP_TSX: begin idx_x_next = sp; nz_val = sp; upd_nz = 1'b1; end
      OP_TXA: begin acc_next = idx_x; nz_val = idx_x; upd_nz = 1'b1; end
      OP_TXS: sp_next = idx_x;
      OP_TYA: begin acc_next = idx_y; nz_val = idx_y; upd_nz = 1'b1; end
      default: begin
      end
    endcase
    // Shifts and rotates share the tail: write back to A or memory.
    if (q_item.op == OP_ASL || q_item.op == OP_LSR ||
        q_item.op == OP_ROL || q_item.op == OP_ROR) begin
      nz_val = sh_val;
      upd_nz = 1'b1;
      if (q_item.shift_acc) begin
        acc_next = sh_val;
      end else begin
        res = sh_val;
      end
    end
    if (upd_nz) begin
      fn_next = nz_val[7];
      fz_next = (nz_val == '0);
    end
  end

  assign q_pop = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      idx_x <= '0;
      idx_y <= '0;
      sp    <= SP_RESET;
      fn    <= 1'b0;
      fv    <= 1'b0;
      fb    <= 1'b0;
      fd    <= 1'b0;
      fi    <= 1'b1;
      fz    <= 1'b0;
      fc    <= 1'b0;
    end else if (q_pop) begin
      acc   <= acc_next;
      idx_x <= idx_x_next;
      idx_y <= idx_y_next;
      sp    <= sp_next;
      fn    <= fn_next;
      fv    <= fv_next;
      fd    <= fd_next;
      fi    <= fi_next;
      fz    <= fz_next;
      fc    <= fc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item.result_byte       <= res;
      out_item.write_memory      <= q_item.mem_write;
      out_item.push_stack        <= q_item.push;
      out_item.branch_taken      <= taken;
      out_item.accumulator_out   <= acc_next;
      out_item.index_x_out       <= idx_x_next;
      out_item.index_y_out       <= idx_y_next;
      out_item.stack_pointer_out <= sp_next;
      out_item.status_out        <= {fn_next, fv_next, 1'b1, fb, fd_next, fi_next,
                                     fz_next, fc_next};
    end
  end

endmodule

`default_nettype wire

// File: rtl/cpu_6502_execute_unit.sv
// Top level of the 6502 execute unit: front decoder, queue, back end.
//
// Execute stage of a 6502-style core, binary arithmetic only. Each input item
// is one instruction kind plus the memory or stack byte it read; each item
// gives exactly one result item with the store/push byte, write and push
// strobes, branch-taken, and A, X, Y, SP and packed status (NV1BDIZC) after
// the instruction. After reset A=X=Y=0, SP=0xFD, status reads 0x24. Kinds
// 51..63 behave as NOP. Throughput is one item per clock while the receiver
// takes every result. The accept edge writes the classified item into the
// queue; a later edge, once the output register is free or being drained,
// runs the ALU pass, updates the register file and loads the output register.
// The queue between decoder and back end holds QUEUE_DEPTH items, so the input
// side keeps accepting while a result waits on the output register.
`default_nettype none

module cpu_6502_execute_unit #(
  parameter int unsigned QUEUE_DEPTH = c65ex_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] operand
  input  wire logic [6:0]  s_tuser,   // [5:0] operation, [6] on_accumulator
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] result_byte, [15:8] accumulator_out, [23:16] index_x_out,
  // [31:24] index_y_out, [39:32] stack_pointer_out, [47:40] status_out
  output logic [47:0]      m_tdata,
  // [0] write_memory, [1] push_stack, [2] branch_taken
  output logic [2:0]       m_tuser
);
  import c65ex_pkg::*;

  dec_t dec;
  dec_t q_item;
  logic q_full;
  logic q_valid;
  logic q_pop;
  res_t res;

  // Front end: pure classification of the incoming item.
  c65ex_decode u_decode (
    .operation      (s_tuser[5:0]),
    .operand        (s_tdata),
    .on_accumulator (s_tuser[6]),
    .dec            (dec)
  );

  // Ready depends only on queue occupancy, never on the output side.
  assign s_tready = !q_full;

  c65ex_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (s_tvalid && s_tready),
    .wr_item   (dec),
    .full      (q_full),
    .rd_en     (q_pop),
    .rd_item   (q_item),
    .not_empty (q_valid)
  );

  // Back end: pops one item per clock while the output register is free
  // or being drained.
  c65ex_execute u_execute (
    .clk       (clk),
    .rst       (rst),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (res)
  );

  assign m_tdata = {res.status_out, res.stack_pointer_out, res.index_y_out,
                    res.index_x_out, res.accumulator_out, res.result_byte};
  assign m_tuser = {res.branch_taken, res.push_stack, res.write_memory};

endmodule

`default_nettype wire

// File: rtl/c65ex_checker.sv
// Port-level checker for the execute unit, bound to the top level.
`default_nettype none

`include "cpu_6502_execute_unit_defines.svh"

module c65ex_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  `C65EX_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output item changed while stalled")
  `C65EX_ASSERT_NOW(a_strobe_excl, m_tvalid, !(m_tuser[0] && m_tuser[1]), "store and push both set")
  `C65EX_ASSERT_NOW(a_byte_zero, m_tvalid && !m_tuser[0] && !m_tuser[1], m_tdata[7:0] == 8'd0, "result byte nonzero without a strobe")
  `C65EX_ASSERT_NOW(a_status_one, m_tvalid, m_tdata[45], "status bit 5 clear")
  `C65EX_ASSERT_NOW(a_branch_excl, m_tvalid && m_tuser[2], !m_tuser[0] && !m_tuser[1], "branch with a store or push")

endmodule

bind cpu_6502_execute_unit c65ex_checker u_checker (.*);

`default_nettype wire

// File: test/cpu_6502_execute_unit_test.sv
// Self-checking stream testbench of the 6502 execute unit with a built-in predictor.
`default_nettype none

module cpu_6502_execute_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import c65ex_pkg::*;

  // Flag bit positions in the packed status NV1BDIZC.
  localparam int FB_C = 0;
  localparam int FB_Z = 1;
  localparam int FB_I = 2;
  localparam int FB_D = 3;
  localparam int FB_V = 6;
  localparam int FB_N = 7;
  localparam logic [7:0] MASK_B = 8'h10;
  localparam logic [7:0] MASK_ONE = 8'h20;

  localparam int RANDOM_ITEMS = 1900;
  localparam int IDLE_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int HOLD_AT = 400;      // results seen before the long receiver hold-off
  localparam int HOLD_CYCLES = 300;
  localparam int REPORT_MAX = 10;
  localparam int TAIL_CYCLES = 8;    // margin after the last result

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS = 2'd0,
    RX_COIN = 2'd1,
    RX_ONE_IN_FOUR = 2'd2,
    RX_MOSTLY = 2'd3
  } rx_mode_t;

  typedef struct packed {
    logic [5:0] op;
    logic [7:0] operand;
    logic on_acc;
  } instr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] operand
  logic [6:0] s_tuser = 7'h00;   // [5:0] operation, [6] on_accumulator
  logic m_tvalid;
  logic m_tready = 1'b0;
  // [7:0] result_byte, [15:8] accumulator_out, [23:16] index_x_out,
  // [31:24] index_y_out, [39:32] stack_pointer_out, [47:40] status_out
  logic [47:0] m_tdata;
  logic [2:0] m_tuser;           // [0] write_memory, [1] push_stack, [2] branch_taken

  cpu_6502_execute_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Instruction items waiting to be offered, and results the predictor expects.
  instr_t pending_instrs[$];
  res_t expected_results[$];

  // Predictor copy of the register file. reg_p keeps bit 5 clear.
  logic [7:0] reg_a, reg_x, reg_y, reg_sp, reg_p;

  int fail_count = 0;
  int results_seen = 0;
  logic in_taken = 1'b0;  // item accepted at the last rising edge

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------
  function automatic void set_nz(input logic [7:0] v);
    reg_p[FB_N] = v[7];
    reg_p[FB_Z] = (v == 8'h00);
  endfunction

  // Binary add with carry in; SBC comes here with the operand inverted.
  function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] m);
    logic [8:0] sum;
    logic [7:0] r;
    sum = {1'b0, a} + {1'b0, m} + {8'h00, reg_p[FB_C]};
    r = sum[7:0];
    reg_p[FB_C] = sum[8];
    reg_p[FB_V] = (~(a[7] ^ m[7])) & (a[7] ^ r[7]);
    set_nz(r);
    return r;
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    reg_p[FB_C] = (r >= m);
    set_nz(r - m);
  endfunction

  // Executes one instruction on the predictor state and returns its result item.
  function automatic res_t exec_instr(input logic [5:0] op, input logic [7:0] m,
                                      input logic on_acc);
    res_t o;
    logic [7:0] v;
    logic cin;
    o = '0;
    v = on_acc ? reg_a : m;
    case (op)
      OP_ADC: reg_a = add_carry(reg_a, m);
      OP_SBC: reg_a = add_carry(reg_a, ~m);
      OP_AND: begin reg_a = reg_a & m; set_nz(reg_a); end
      OP_ORA: begin reg_a = reg_a | m; set_nz(reg_a); end
      OP_EOR: begin reg_a = reg_a ^ m; set_nz(reg_a); end
      OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
        cin = reg_p[FB_C];
        case (op)
          OP_ASL: begin reg_p[FB_C] = v[7]; v = {v[6:0], 1'b0}; end
          OP_ROL: begin reg_p[FB_C] = v[7]; v = {v[6:0], cin}; end
          OP_LSR: begin reg_p[FB_C] = v[0]; v = {1'b0, v[7:1]}; end
          default: begin reg_p[FB_C] = v[0]; v = {cin, v[7:1]}; end
        endcase
        set_nz(v);
        if (on_acc) begin
          reg_a = v;
        end else begin
          o.result_byte = v;
          o.write_memory = 1'b1;
        end
      end
      OP_BCC: o.branch_taken = !reg_p[FB_C];
      OP_BCS: o.branch_taken = reg_p[FB_C];
      OP_BEQ: o.branch_taken = reg_p[FB_Z];
      OP_BNE: o.branch_taken = !reg_p[FB_Z];
      OP_BMI: o.branch_taken = reg_p[FB_N];
      OP_BPL: o.branch_taken = !reg_p[FB_N];
      OP_BVC: o.branch_taken = !reg_p[FB_V];
      OP_BVS: o.branch_taken = reg_p[FB_V];
      OP_BIT: begin
        reg_p[FB_N] = m[7];
        reg_p[FB_V] = m[6];
        reg_p[FB_Z] = ((reg_a & m) == 8'h00);
      end
      OP_CLC: reg_p[FB_C] = 1'b0;
      OP_CLD: reg_p[FB_D] = 1'b0;
      OP_CLI: reg_p[FB_I] = 1'b0;
      OP_CLV: reg_p[FB_V] = 1'b0;
      OP_SEC: reg_p[FB_C] = 1'b1;
      OP_SED: reg_p[FB_D] = 1'b1;
      OP_SEI: reg_p[FB_I] = 1'b1;
      OP_CMP: compare_reg(reg_a, m);
      OP_CPX: compare_reg(reg_x, m);
      OP_CPY: compare_reg(reg_y, m);
      OP_DEC: begin o.result_byte = m - 8'd1; set_nz(o.result_byte); o.write_memory = 1'b1; end
      OP_INC: begin o.result_byte = m + 8'd1; set_nz(o.result_byte); o.write_memory = 1'b1; end
      OP_DEX: begin reg_x = reg_x - 8'd1; set_nz(reg_x); end
      OP_DEY: begin reg_y = reg_y - 8'd1; set_nz(reg_y); end
      OP_INX: begin reg_x = reg_x + 8'd1; set_nz(reg_x); end
      OP_INY: begin reg_y = reg_y + 8'd1; set_nz(reg_y); end
      OP_LDA: begin reg_a = m; set_nz(m); end
      OP_LDX: begin reg_x = m; set_nz(m); end
      OP_LDY: begin reg_y = m; set_nz(m); end
      // Pushes write at the old SP, then SP moves down.
      OP_PHA: begin o.result_byte = reg_a; o.push_stack = 1'b1; reg_sp = reg_sp - 8'd1; end
      OP_PHP: begin
        o.result_byte = reg_p | MASK_B | MASK_ONE;
        o.push_stack = 1'b1;
        reg_sp = reg_sp - 8'd1;
      end
      // Pulls bump SP first; the operand carries the pulled byte.
      OP_PLA: begin reg_sp = reg_sp + 8'd1; reg_a = m; set_nz(m); end
      OP_PLP: begin
        reg_sp = reg_sp + 8'd1;
        reg_p = (reg_p & MASK_B) | (m & ~(MASK_B | MASK_ONE));
      end
      OP_STA: begin o.result_byte = reg_a; o.write_memory = 1'b1; end
      OP_STX: begin o.result_byte = reg_x; o.write_memory = 1'b1; end
      OP_STY: begin o.result_byte = reg_y; o.write_memory = 1'b1; end
      OP_TAX: begin reg_x = reg_a; set_nz(reg_x); end
      OP_TAY: begin reg_y = reg_a; set_nz(reg_y); end
      OP_TSX: begin reg_x = reg_sp; set_nz(reg_x); end
      OP_TXA: begin reg_a = reg_x; set_nz(reg_a); end
      OP_TXS: reg_sp = reg_x;  // flags untouched
      OP_TYA: begin reg_a = reg_y; set_nz(reg_a); end
      default: ;  // NOP and the unused kinds above TYA
    endcase
    o.accumulator_out = reg_a;
    o.index_x_out = reg_x;
    o.index_y_out = reg_y;
    o.stack_pointer_out = reg_sp;
    o.status_out = reg_p | MASK_ONE;
    return o;
  endfunction

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_MAX)
        $display("mismatch on result %0d, %s: expected %02h, got %02h",
                 results_seen, name, want, got);
    end
  endtask

  // Monitor: checks result items and feeds accepted input items to the predictor.
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      in_taken <= 1'b0;
      reg_a = 8'h00;
      reg_x = 8'h00;
      reg_y = 8'h00;
      reg_sp = SP_RESET;
      reg_p = 8'h00;
      reg_p[FB_I] = 1'b1;
    end else begin
      in_taken <= s_tvalid && s_tready;
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected result item %0d: tdata %012h tuser %01h",
                     results_seen, m_tdata, m_tuser);
        end else begin
          want = expected_results.pop_front();
          check_field("result_byte", want.result_byte, m_tdata[7:0]);
          check_field("accumulator_out", want.accumulator_out, m_tdata[15:8]);
          check_field("index_x_out", want.index_x_out, m_tdata[23:16]);
          check_field("index_y_out", want.index_y_out, m_tdata[31:24]);
          check_field("stack_pointer_out", want.stack_pointer_out, m_tdata[39:32]);
          check_field("status_out", want.status_out, m_tdata[47:40]);
          check_field("write_memory", {7'h00, want.write_memory}, {7'h00, m_tuser[0]});
          check_field("push_stack", {7'h00, want.push_stack}, {7'h00, m_tuser[1]});
          check_field("branch_taken", {7'h00, want.branch_taken}, {7'h00, m_tuser[2]});
        end
      end
      if (s_tvalid && s_tready)
        expected_results.push_back(exec_instr(s_tuser[5:0], s_tdata, s_tuser[6]));
    end
  end

  // ------------------------------------------------------------------
  // Driver: bursts of items with random gaps, changes on the falling edge
  // ------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    instr_t nxt;
    logic valid_nxt;
    valid_nxt = s_tvalid;
    if (rst) begin
      valid_nxt = 1'b0;
    end else if (!s_tvalid || in_taken) begin
      // Current item gone (or none shown): idle a while or offer the next one.
      if (gap_left > 0) begin
        gap_left--;
        valid_nxt = 1'b0;
      end else if (pending_instrs.size() > 0) begin
        nxt = pending_instrs.pop_front();
        valid_nxt = 1'b1;
        s_tdata <= nxt.operand;
        s_tuser <= {nxt.on_acc, nxt.op};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          // About a third of the bursts run back to back with no gap.
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
    s_tvalid <= valid_nxt;
  end

  // ------------------------------------------------------------------
  // Receiver: changing stall patterns, plus one long hold-off so the
  // queue fills and the input side has to stall.
  // ------------------------------------------------------------------
  rx_mode_t rx_mode = RX_ALWAYS;
  int mode_left = 0;
  int rx_phase = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    logic ready_nxt;
    ready_nxt = 1'b0;
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
      end else begin
        if (mode_left <= 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        rx_phase++;
        case (rx_mode)
          RX_ALWAYS: ready_nxt = 1'b1;
          RX_COIN: ready_nxt = 1'($urandom_range(0, 1));
          RX_ONE_IN_FOUR: ready_nxt = (rx_phase % 4 == 0);
          default: ready_nxt = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
    m_tready <= ready_nxt;
  end

  // ------------------------------------------------------------------
  // Watchdog: ends the run when no item moves for too long
  // ------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("FAIL cpu_6502_execute_unit");
          $finish;
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  task automatic add_instr(input logic [5:0] op, input logic [7:0] m, input logic on_acc);
    instr_t it;
    it.op = op;
    it.operand = m;
    it.on_acc = on_acc;
    pending_instrs.push_back(it);
  endtask

  // Operand with a bias toward the byte corners.
  function automatic logic [7:0] pick_operand();
    case ($urandom_range(0, 11))
      0: return 8'h00;
      1: return ALL_ONES;
      2: return SIGN_MASK;
      3: return 8'h7F;
      4: return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly real kinds; now and then one of the unused kinds above TYA.
  function automatic logic [5:0] pick_op();
    if ($urandom_range(0, 9) == 0)
      return 6'($urandom_range(int'(OP_TYA) + 1, 63));
    return 6'($urandom_range(0, int'(OP_TYA)));
  endfunction

  initial begin
    int count;
    int run_len;
    logic [5:0] run_op;

    // Directed: flag corners, stack handling, shifts on both targets.
    add_instr(OP_PHP, 8'h00, 1'b0);          // status right after reset, B and bit 5 set
    add_instr(OP_LDA, 8'h7F, 1'b1);          // accumulator select ignored here
    add_instr(OP_ADC, 8'h01, 1'b0);          // signed overflow 7F+01
    add_instr(OP_BVS, 8'h00, 1'b0);
    add_instr(OP_BMI, 8'h00, 1'b0);
    add_instr(OP_ADC, ALL_ONES, 1'b0);       // carry out and overflow, result 7F
    add_instr(OP_BNE, 8'h00, 1'b0);
    add_instr(OP_SBC, SIGN_MASK, 1'b0);      // borrow and overflow
    add_instr(OP_BVC, 8'h00, 1'b0);
    add_instr(OP_CPX, ALL_ONES, 1'b0);
    add_instr(OP_BIT, 8'hC0, 1'b0);          // N and V from memory, Z from A AND M
    add_instr(OP_PLP, ALL_ONES, 1'b0);       // B and bit 5 of the pulled byte ignored
    add_instr(OP_PHP, 8'h00, 1'b0);
    add_instr(OP_PLP, 8'h00, 1'b0);
    add_instr(OP_LDX, 8'h00, 1'b0);
    add_instr(OP_TXS, 8'h00, 1'b0);          // SP to zero, flags untouched
    add_instr(OP_PHA, 8'h00, 1'b0);          // SP wraps below zero
    add_instr(OP_PLA, SIGN_MASK, 1'b0);      // and back up
    add_instr(OP_TSX, 8'h00, 1'b0);
    add_instr(OP_ASL, ALL_ONES, 1'b0);       // memory shift with store
    add_instr(OP_ROR, 8'h00, 1'b1);          // carry rotated into A
    add_instr(OP_ROL, SIGN_MASK, 1'b0);
    add_instr(OP_LSR, 8'h01, 1'b1);
    add_instr(OP_INC, ALL_ONES, 1'b0);
    add_instr(OP_DEC, 8'h00, 1'b0);
    add_instr(6'd63, ALL_ONES, 1'b1);        // unused kind acts as NOP

    // Random part: single instructions, with runs of pushes or pulls so that
    // SP walks across its wrap points.
    count = 0;
    while (count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        run_len = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0: run_op = OP_PHA;
          1: run_op = OP_PHP;
          2: run_op = OP_PLA;
          default: run_op = OP_PLP;
        endcase
        repeat (run_len) add_instr(run_op, pick_operand(), 1'($urandom_range(0, 1)));
        count += run_len;
      end else begin
        add_instr(pick_op(), pick_operand(), 1'($urandom_range(0, 1)));
        count++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Everything offered and taken, then every result back, then a short tail.
    while (pending_instrs.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS cpu_6502_execute_unit");
    end else begin
      $display("FAIL cpu_6502_execute_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
+incdir+rtl
rtl/c65ex_pkg.sv
rtl/c65ex_decode.sv
rtl/c65ex_queue.sv
rtl/c65ex_execute.sv
rtl/cpu_6502_execute_unit.sv
rtl/c65ex_checker.sv
test/cpu_6502_execute_unit_test.sv
